// ===== rtl/tkh_pkg.sv =====
// Package for the top-k heap keeper: record type and operation codes.
// No dependencies.
`default_nettype none
package tkh_pkg;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned SCORE_W = 36;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_FLUSH  = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [KEY_W-1:0]   key_a;
    logic signed [KEY_W-1:0]   key_b;
    logic signed [KEY_W-1:0]   key_c;
    logic signed [KEY_W-1:0]   key_d;
    logic signed [KEY_W-1:0]   key_e;
    logic signed [SCORE_W-1:0] score;
  } rec_t;

  typedef struct packed {
    op_t  op;
    rec_t rec;
  } cmd_t;

  localparam int unsigned REC_W = $bits(rec_t);
  localparam int unsigned CMD_W = $bits(cmd_t);
endpackage
`default_nettype wire

// ===== rtl/tkh_if.sv =====
// Valid/ready channel interfaces for the top-k heap keeper.
// Depends on tkh_pkg.
`default_nettype none
interface tkh_in_if;
  import tkh_pkg::*;
  logic valid;
  logic ready;
  logic operation;
  logic signed [KEY_W-1:0] key_a, key_b, key_c, key_d, key_e;
  logic signed [SCORE_W-1:0] score;
  modport source (output valid, operation, key_a, key_b, key_c, key_d, key_e, score,
                  input ready);
  modport sink (input valid, operation, key_a, key_b, key_c, key_d, key_e, score,
                output ready);
endinterface

interface tkh_out_if;
  import tkh_pkg::*;
  logic valid;
  logic ready;
  logic signed [KEY_W-1:0] res_a, res_b, res_c, res_d, res_e;
  logic signed [SCORE_W-1:0] res_score;
  logic last_of_run;
  modport source (output valid, res_a, res_b, res_c, res_d, res_e, res_score,
                  last_of_run, input ready);
  modport sink (input valid, res_a, res_b, res_c, res_d, res_e, res_score,
                last_of_run, output ready);
endinterface

interface tkh_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] top_k;
  modport source (output valid, top_k, input ready);
  modport sink (input valid, top_k, output ready);
endinterface
`default_nettype wire

// ===== rtl/tkh_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module tkh_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== rtl/tkh_front.sv =====
// Front end: accept input transactions and queue them as commands.
// Depends on tkh_pkg.
`default_nettype none
module tkh_front
  import tkh_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire cmd_t in_cmd,
  output logic      q_valid,
  input  wire logic q_pop,
  output cmd_t      q_cmd
);
  // two-entry queue
  cmd_t       slot_r [2];
  logic       rd_ptr_r, wr_ptr_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= in_cmd;
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue pop while empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
endmodule
`default_nettype wire

// ===== rtl/tkh_back.sv =====
// Back end: heap sequencer over one record RAM; inserts, sifts, flushes.
// Depends on tkh_pkg and tkh_ram.
`default_nettype none
module tkh_back
  import tkh_pkg::*;
#(
  parameter int unsigned MAX_K = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [$clog2(MAX_K+1)-1:0] top_k,
  input  wire logic                       q_valid,
  input  wire cmd_t                       q_cmd,
  output logic                            q_pop,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output rec_t                            out_rec,
  output logic                            out_last
);
  localparam int unsigned AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int unsigned CW = $clog2(MAX_K+1);

  typedef enum logic [3:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RDL, S_DN_RDR, S_DN_CMP, S_DN_WR,
    S_FL_RD, S_FL_WAIT, S_FL_OUT
  } state_t;

  state_t        state_r;
  logic [CW-1:0] held_r;
  logic [AW-1:0] pos_r, other_r;
  logic [CW-1:0] flush_idx_r;
  rec_t          cur_r, left_r, best_r;
  logic          best_is_r_r;
  logic          out_valid_r, out_last_r;
  rec_t          out_rec_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  rec_t          wdata, rdata;
  logic [REC_W-1:0] rdata_raw;

  tkh_ram #(.WIDTH(REC_W), .DEPTH(1 << AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata_raw)
  );
  assign rdata = rec_t'(rdata_raw);

  // sequencing helpers
  logic [AW:0] lc_w, rc_w;
  assign lc_w = {pos_r, 1'b1};
  assign rc_w = {pos_r, 1'b0} + {{AW{1'b0}}, 1'b1} + {{AW{1'b0}}, 1'b1};
  logic [AW-1:0] parent_w;
  assign parent_w = AW'((pos_r - 1'b1) >> 1);
  logic full_w;
  assign full_w = !(held_r < top_k) || (held_r >= CW'(MAX_K));
  // right child wins only when it exists and is strictly smaller than the left
  logic use_right_w;
  assign use_right_w = (rc_w < (AW+1)'(held_r)) && (rdata.score < left_r.score);

  assign out_valid = out_valid_r;
  assign out_rec   = out_rec_r;
  assign out_last  = out_last_r;

  always_comb begin
    we = 1'b0; waddr = pos_r; wdata = cur_r; raddr = pos_r; q_pop = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        q_pop = q_valid;
        raddr = '0;
      end
      S_UP_RD:  raddr = parent_w;
      S_DN_RDL: raddr = lc_w[AW-1:0];
      S_DN_RDR: raddr = rc_w[AW-1:0];
      S_DN_WR: begin
        // move the smaller child up into pos, or place the new record there
        we = 1'b1; waddr = pos_r; wdata = best_r;
      end
      S_UP_CMP: begin
        we = 1'b1;
        if (cur_r.score < rdata.score) begin
          waddr = pos_r; wdata = rdata;
        end else begin
          waddr = pos_r; wdata = cur_r;
        end
      end
      S_DN_CMP: ;
      S_FL_RD:  raddr = flush_idx_r[AW-1:0];
      S_FL_WAIT, S_FL_OUT: raddr = flush_idx_r[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
      other_r     <= '0;
      best_is_r_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_FL_OUT) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (q_valid) begin
          cur_r <= q_cmd.rec;
          if (q_cmd.op == OP_FLUSH) begin
            flush_idx_r <= '0;
            if (held_r != '0) state_r <= S_FL_RD;
          end else if (!full_w) begin
            pos_r  <= AW'(held_r);
            held_r <= held_r + 1'b1;
            if (held_r == '0) state_r <= S_DN_WR;
            else state_r <= S_UP_RD;
            best_r <= q_cmd.rec;
          end else if (held_r != '0) begin
            // root read was issued this cycle; compare in sift-down setup
            pos_r   <= '0;
            state_r <= S_DN_CMP;
            best_is_r_r <= 1'b1; // marks root check
          end
        end
        S_UP_RD: state_r <= S_UP_CMP;
        S_UP_CMP: begin
          if (cur_r.score < rdata.score) begin
            pos_r <= parent_w;
            if (parent_w == '0) begin
              best_r <= cur_r; state_r <= S_DN_WR; other_r <= '0;
            end else state_r <= S_UP_RD;
          end else state_r <= S_IDLE;
        end
        S_DN_CMP: begin
          // root compare for a replacement
          if (best_is_r_r) begin
            best_is_r_r <= 1'b0;
            if (cur_r.score > rdata.score) begin
              if (lc_w < (AW+1)'(held_r)) state_r <= S_DN_RDL;
              else begin best_r <= cur_r; state_r <= S_DN_WR; end
            end else state_r <= S_IDLE;
          end
        end
        S_DN_RDL: state_r <= S_DN_RDR;
        S_DN_RDR: begin
          left_r  <= rdata;
          state_r <= S_FL_WAIT; // reuse as child select step
          other_r <= '1;
        end
        S_DN_WR: begin
          if (other_r == '1) begin
            // child moved up; continue from child slot
            pos_r <= best_is_r_r ? rc_w[AW-1:0] : lc_w[AW-1:0];
            best_is_r_r <= 1'b0;
            other_r <= '0;
            if ({(best_is_r_r ? rc_w[AW-1:0] : lc_w[AW-1:0]), 1'b1} < (AW+1)'(held_r))
              state_r <= S_DN_RDL;
            else begin best_r <= cur_r; state_r <= S_DN_WR; end
          end else state_r <= S_IDLE;
        end
        S_FL_RD: state_r <= S_FL_WAIT;
        S_FL_WAIT: begin
          if (other_r == '1) begin
            // child selection: left in left_r, right in rdata
            if (use_right_w ? (rdata.score < cur_r.score) : (left_r.score < cur_r.score)) begin
              best_r <= use_right_w ? rdata : left_r;
              best_is_r_r <= use_right_w;
              state_r <= S_DN_WR;
            end else begin
              best_r <= cur_r; other_r <= '0; state_r <= S_DN_WR;
            end
          end else state_r <= S_FL_OUT;
        end
        S_FL_OUT: if (!out_valid_r || out_ready) begin
          out_valid_r <= 1'b1;
          out_rec_r   <= rdata;
          out_last_r  <= (flush_idx_r + 1'b1 == held_r);
          if (flush_idx_r + 1'b1 == held_r) begin
            held_r <= '0; state_r <= S_IDLE;
          end else begin
            flush_idx_r <= flush_idx_r + 1'b1; state_r <= S_FL_RD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CW'(MAX_K)) else $error("held count beyond capacity");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE) else $error("pop outside idle");
  a_last_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r && $rose(out_valid_r)) |-> held_r == '0)
    else $error("last result left entries held");
endmodule
`default_nettype wire

// ===== rtl/top_k_heap_keeper_core.sv =====
// Top level of the top-k heap keeper: front queue, heap back end, config.
// Depends on tkh_pkg, tkh_if, tkh_front, tkh_back, tkh_ram.
// An insert passes through the queue, then sifts up or down the heap one level at a time;
// items run one at a time. A flush emits the held records one by one in storage order,
// waiting whenever the receiver stalls.
// Reset (synchronous, rst_n low): heap empty, top_k = MAX_K capped at 16.
`default_nettype none
module top_k_heap_keeper_core
  import tkh_pkg::*;
#(
  parameter int unsigned MAX_K = 16
) (
  input wire logic clk,
  input wire logic rst_n,
  tkh_in_if.sink   in_ch,
  tkh_out_if.source out_ch,
  tkh_cfg_if.sink  cfg_ch
);
  localparam int unsigned CW = $clog2(MAX_K+1);
  localparam int unsigned KRST = (MAX_K < 16) ? MAX_K : 16;

  logic [CW-1:0] top_k_r;
  logic [4:0]    cfg_v;

  // clamp the write: zero acts as one, above capacity acts as capacity
  assign cfg_ch.ready = 1'b1;
  assign cfg_v = cfg_ch.top_k;
  always_ff @(posedge clk) begin
    if (!rst_n) top_k_r <= CW'(KRST);
    else if (cfg_ch.valid) begin
      if (cfg_v == 5'd0) top_k_r <= CW'(1);
      else if (32'(cfg_v) > MAX_K) top_k_r <= CW'(MAX_K);
      else top_k_r <= CW'(cfg_v);
    end
  end

  cmd_t in_cmd, q_cmd;
  logic q_valid, q_pop;
  rec_t out_rec;

  assign in_cmd.op        = op_t'(in_ch.operation);
  assign in_cmd.rec.key_a = in_ch.key_a;
  assign in_cmd.rec.key_b = in_ch.key_b;
  assign in_cmd.rec.key_c = in_ch.key_c;
  assign in_cmd.rec.key_d = in_ch.key_d;
  assign in_cmd.rec.key_e = in_ch.key_e;
  assign in_cmd.rec.score = in_ch.score;

  tkh_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
  );

  tkh_back #(.MAX_K(MAX_K)) u_back (
    .clk(clk), .rst_n(rst_n), .top_k(top_k_r), .q_valid(q_valid), .q_cmd(q_cmd),
    .q_pop(q_pop), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_rec(out_rec), .out_last(out_ch.last_of_run)
  );

  assign out_ch.res_a     = out_rec.key_a;
  assign out_ch.res_b     = out_rec.key_b;
  assign out_ch.res_c     = out_rec.key_c;
  assign out_ch.res_d     = out_rec.key_d;
  assign out_ch.res_e     = out_rec.key_e;
  assign out_ch.res_score = out_rec.score;

  a_topk_range: assert property (@(posedge clk) disable iff (!rst_n)
    top_k_r != '0 && top_k_r <= CW'(MAX_K)) else $error("top_k out of range");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=>
      (out_ch.valid && $stable(out_rec) && $stable(out_ch.last_of_run)))
    else $error("result changed while stalled");
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ch.ready) else $error("config port not ready");
endmodule
`default_nettype wire

// ===== sim/top_k_heap_keeper_core_test.sv =====
// Self-checking test of top_k_heap_keeper_core: random and directed inserts and
// flushes, checked against a heap predictor kept in the test. Depends on tkh_pkg
// and the channel interfaces in tkh_if.
module top_k_heap_keeper_core_test;
  import tkh_pkg::*;

  localparam int unsigned CAP = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  tkh_in_if  in_ch ();
  tkh_out_if out_ch ();
  tkh_cfg_if cfg_ch ();

  top_k_heap_keeper_core #(.MAX_K(CAP)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // Result record as it leaves the block.
  typedef struct packed {
    rec_t rec;
    logic last;
  } emit_t;

  // Predictor state: heap storage, fill level, kept count.
  rec_t        heap_q[CAP];
  int unsigned held_n;
  int unsigned keep_k;
  emit_t       emits_pending[$];

  int  errors = 0;
  bit  hold_off = 1'b0;   // long receiver stall requested
  int  burst_left = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = 1'b0;
    in_ch.key_a = '0; in_ch.key_b = '0; in_ch.key_c = '0;
    in_ch.key_d = '0; in_ch.key_e = '0; in_ch.score = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.top_k = '0;
  end

  // Swap two heap slots of the predictor.
  task automatic swap_slots(int unsigned x, int unsigned y);
    rec_t t;
    t = heap_q[x]; heap_q[x] = heap_q[y]; heap_q[y] = t;
  endtask

  // Advance the predictor by one transaction.
  task automatic predict_heap(op_t op, rec_t r);
    int unsigned pos, up, best, lc, rc;
    if (op == OP_FLUSH) begin
      for (int unsigned i = 0; i < held_n; i++)
        emits_pending.push_back('{rec: heap_q[i], last: (i + 1 == held_n)});
      held_n = 0;
    end else if (held_n < keep_k && held_n < CAP) begin
      heap_q[held_n] = r;
      pos = held_n;
      while (pos > 0) begin
        up = (pos - 1) / 2;
        if (!(heap_q[pos].score < heap_q[up].score)) break;
        swap_slots(pos, up);
        pos = up;
      end
      held_n++;
    end else if (held_n > 0 && r.score > heap_q[0].score) begin
      heap_q[0] = r;
      pos = 0;
      forever begin
        best = pos; lc = 2 * pos + 1; rc = 2 * pos + 2;
        if (lc < held_n && heap_q[lc].score < heap_q[best].score) best = lc;
        if (rc < held_n && heap_q[rc].score < heap_q[best].score) best = rc;
        if (best == pos) break;
        swap_slots(pos, best);
        pos = best;
      end
    end
  endtask

  // Send one transaction, honoring the burst/gap pattern. Valid stays high
  // between transactions of a burst and drops only for a gap or a drain.
  task automatic send_item(op_t op, rec_t r);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? int'($urandom_range(1, 12)) : 0;
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.key_a <= r.key_a; in_ch.key_b <= r.key_b; in_ch.key_c <= r.key_c;
    in_ch.key_d <= r.key_d; in_ch.key_e <= r.key_e; in_ch.score <= r.score;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_heap(op, r);
  endtask

  function automatic rec_t rand_rec(bit narrow);
    rec_t r;
    r.key_a = $urandom; r.key_b = $urandom; r.key_c = $urandom;
    r.key_d = $urandom; r.key_e = $urandom;
    if (narrow) r.score = 36'($signed($urandom_range(0, 40)) - 20);
    else r.score = {4'($urandom_range(0, 15)), $urandom};
    return r;
  endfunction

  // Stop offering, wait for every expected emission, then let the block settle.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (emits_pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_top_k(logic [4:0] v);
    drain_results();
    cfg_ch.valid <= 1'b1;
    cfg_ch.top_k <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    keep_k = (v == 0) ? 1 : (v > CAP ? CAP : v);
  endtask

  // Receiver: stall on its own pattern, or hold off completely on request.
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 3) != 0);
  end

  // Check each emitted record against the oldest expectation.
  always @(posedge clk) begin
    emit_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.rec = '{out_ch.res_a, out_ch.res_b, out_ch.res_c, out_ch.res_d,
                  out_ch.res_e, out_ch.res_score};
      got.last = out_ch.last_of_run;
      if (emits_pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = emits_pending.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %h actual %h", $time, want, got);
          errors++;
        end
      end
    end
  end

  // Directed: extremes of scores and keys, ties, flushes, empty flush.
  task automatic test_directed();
    rec_t r;
    send_item(OP_FLUSH, rand_rec(0));           // flush of an empty store
    r = '{'1, '1, '1, '1, '1, 36'sh7_FFFF_FFFF};
    send_item(OP_INSERT, r);
    r = '{32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0, '1, 36'sh8_0000_0000};
    send_item(OP_INSERT, r);
    r = '{0, 0, 0, 0, 0, 0};
    send_item(OP_INSERT, r);
    send_item(OP_INSERT, r);                    // score equal to an earlier record
    send_item(OP_FLUSH, r);
    for (int i = 0; i < 18; i++) send_item(OP_INSERT, rand_rec(1));
    send_item(OP_FLUSH, rand_rec(0));
  endtask

  // Small or clamped top_k: replacement, drops and tie-breaking on the way down.
  task automatic test_small_k(logic [4:0] v);
    write_top_k(v);
    for (int i = 0; i < 20; i++) send_item(OP_INSERT, rand_rec(1));
    send_item(OP_FLUSH, rand_rec(0));
  endtask

  // top_k lowered under the fill level: heap counts as full, keeps all.
  task automatic test_lowered_k();
    write_top_k(5'd16);
    for (int i = 0; i < 10; i++) send_item(OP_INSERT, rand_rec(1));
    write_top_k(5'd3);
    for (int i = 0; i < 10; i++) send_item(OP_INSERT, rand_rec(1));
    send_item(OP_FLUSH, rand_rec(0));
  endtask

  // Long receiver hold-off while inserts and flushes keep coming.
  task automatic test_backpressure();
    write_top_k(5'd16);
    hold_off = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 40; i++)
        send_item((i % 10 == 9) ? OP_FLUSH : OP_INSERT, rand_rec(i[0]));
    join
  endtask

  // Random mix: mostly inserts, occasional flushes, varying top_k.
  task automatic test_random();
    logic [4:0] kv;
    for (int i = 0; i < 40; i++) begin
      if (i % 20 == 0) begin
        kv = 5'($urandom_range(0, 31));
        write_top_k(kv);
      end
      send_item(($urandom_range(0, 9) == 0) ? OP_FLUSH : OP_INSERT,
                rand_rec(1'($urandom_range(0, 1))));
    end
    send_item(OP_FLUSH, rand_rec(0));
  endtask

  initial begin
    held_n = 0;
    keep_k = CAP;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_small_k(5'd1);
    test_small_k(5'd0);
    test_small_k(5'd31);
    test_small_k(5'd4);
    test_lowered_k();
    test_backpressure();
    test_random();
    drain_results();
    if (errors == 0) $display("top_k_heap_keeper_core_test: PASS");
    else $display("top_k_heap_keeper_core_test: FAIL");
    $finish;
  end

  // Timeout guard.
  initial begin
    #3000000;
    $display("top_k_heap_keeper_core_test: FAIL");
    $finish;
  end
endmodule
